FILE: hdl/sequential_list_engine_unit_macros.svh
// Assertion macros for the list engine.
// Depends on nothing; included by sle_ctrl, the module that asserts.
`ifndef SEQUENTIAL_LIST_ENGINE_UNIT_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define SLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: hdl/sle_pkg.sv
// Shared types, codes and sizes of the list engine.
// Depends on nothing.
package sle_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 7;

    typedef logic signed [31:0] elem_t;

    // Operation codes of an input transfer
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_FIND   = 2'd3;

    // Status codes of a result
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_BADPOS   = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    // Commands broadcast to the cell chain
    localparam logic [2:0] CMD_HOLD   = 3'd0;
    localparam logic [2:0] CMD_APPEND = 3'd1;
    localparam logic [2:0] CMD_INSERT = 3'd2;
    localparam logic [2:0] CMD_DELETE = 3'd3;
    localparam logic [2:0] CMD_ROTATE = 3'd4;

    typedef struct packed {
        logic [2:0]       kind;
        logic [IDX_W-1:0] pos;    // 0-based target entry
        logic [CNT_W-1:0] count;  // current list length
    } cell_cmd_t;

endpackage

FILE: hdl/sequential_list_engine_unit.sv
// Top level of the list engine: a chain of element cells and its sequencer.
// Depends on sle_pkg, sle_cell and sle_ctrl.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | in_valid / in_stall | op, position, value
//  output   | out_valid/out_stall | status, match_position, match_index,
//           |                     | length, last
//
// Append, insert and delete: the whole chain moves its entries in the
// accept cycle and the single result is registered at once.
// Find: the accept cycle, then the list rotates through the head cell one
// entry per cycle, while the output is not stalled, against one comparator,
// then the final result is flushed.
// Reset clears the length, the sequencer and the result valid; the cells
// themselves are not reset.
// A stalled output freezes the scan; no input is taken while a find runs.
module sequential_list_engine_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [1:0]     op,
    input  logic [6:0]     position,
    input  sle_pkg::elem_t value,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [1:0]     status,
    output logic [6:0]     match_position,
    output logic [6:0]     match_index,
    output logic [6:0]     length,
    output logic           last
);

    sle_pkg::cell_cmd_t cmd;
    sle_pkg::elem_t     cell_data [sle_pkg::CAPACITY];
    sle_pkg::elem_t     low_in    [sle_pkg::CAPACITY];
    sle_pkg::elem_t     high_in   [sle_pkg::CAPACITY];

    sle_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .position       (position),
        .value          (value),
        .head_data      (cell_data[0]),
        .cmd            (cmd),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .match_position (match_position),
        .match_index    (match_index),
        .length         (length),
        .last           (last)
    );

    // Build the chain: each cell sees its lower and upper neighbor, the
    // head cell for the wrap of a rotation, and the incoming value.
    for (genvar g = 0; g < sle_pkg::CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            assign low_in[g] = '0;
        end
        else
        begin : g_low
            assign low_in[g] = cell_data[g-1];
        end

        if (g == sle_pkg::CAPACITY - 1)
        begin : g_top
            assign high_in[g] = cell_data[g];
        end
        else
        begin : g_high
            assign high_in[g] = cell_data[g+1];
        end

        sle_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .cell_idx  (sle_pkg::IDX_W'(g)),
            .low_data  (low_in[g]),
            .high_data (high_in[g]),
            .head_data (cell_data[0]),
            .load_data (value),
            .data      (cell_data[g])
        );
    end

endmodule

FILE: hdl/sle_cell.sv
// One storage cell of the list chain: holds one element and moves it to a neighbor.
// Depends on sle_pkg.
module sle_cell (
    input  logic                      clk,
    input  sle_pkg::cell_cmd_t        cmd,
    input  logic [sle_pkg::IDX_W-1:0] cell_idx,
    input  sle_pkg::elem_t            low_data,
    input  sle_pkg::elem_t            high_data,
    input  sle_pkg::elem_t            head_data,
    input  sle_pkg::elem_t            load_data,
    output sle_pkg::elem_t            data
);

    sle_pkg::elem_t                data_reg;
    sle_pkg::elem_t                data_next;
    logic [sle_pkg::CNT_W-1:0]     idx_ext;
    logic [sle_pkg::CNT_W-1:0]     idx_inc;
    logic [sle_pkg::CNT_W-1:0]     pos_ext;

    assign idx_ext = sle_pkg::CNT_W'(cell_idx);
    assign idx_inc = idx_ext + sle_pkg::CNT_W'(1);
    assign pos_ext = sle_pkg::CNT_W'(cmd.pos);

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.kind)
            sle_pkg::CMD_HOLD:
            begin
                data_next = data_reg;
            end
            sle_pkg::CMD_APPEND:
            begin
                if (idx_ext == pos_ext)
                    data_next = load_data;
            end
            sle_pkg::CMD_INSERT:
            begin
                // open a slot at pos, push the tail up by one
                if (idx_ext == pos_ext)
                    data_next = load_data;
                else if (idx_ext > pos_ext && idx_ext <= cmd.count)
                    data_next = low_data;
            end
            sle_pkg::CMD_DELETE:
            begin
                // close the gap at pos, pull the tail down by one
                if (idx_ext >= pos_ext && idx_inc < cmd.count)
                    data_next = high_data;
            end
            sle_pkg::CMD_ROTATE:
            begin
                if (idx_inc < cmd.count)
                    data_next = high_data;
                else if (idx_inc == cmd.count)
                    data_next = head_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: hdl/sle_ctrl.sv
// Sequencer of the list engine: decodes operations, keeps the length,
// drives the cell chain and holds the result register. Depends on sle_pkg
// and sequential_list_engine_unit_macros.svh.
`include "sequential_list_engine_unit_macros.svh"

module sle_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                op,
    input  logic [6:0]                position,
    input  sle_pkg::elem_t            value,
    input  sle_pkg::elem_t            head_data,
    output sle_pkg::cell_cmd_t        cmd,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                status,
    output logic [6:0]                match_position,
    output logic [6:0]                match_index,
    output logic [6:0]                length,
    output logic                      last
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    localparam logic [sle_pkg::CNT_W-1:0] CAP_CNT = sle_pkg::CNT_W'(sle_pkg::CAPACITY);
    localparam logic [sle_pkg::CNT_W-1:0] ONE     = sle_pkg::CNT_W'(1);

    logic [1:0]                state_reg, state_next;
    logic [sle_pkg::CNT_W-1:0] count_reg, count_next;
    logic [sle_pkg::CNT_W-1:0] scan_reg, scan_next;
    sle_pkg::elem_t            key_reg, key_next;
    logic                      pend_valid_reg, pend_valid_next;
    logic [6:0]                pend_pos_reg, pend_pos_next;
    logic [6:0]                pend_idx_reg, pend_idx_next;

    logic                      out_valid_reg, out_valid_next;
    logic [1:0]                status_reg, status_next;
    logic [6:0]                mpos_reg, mpos_next;
    logic [6:0]                midx_reg, midx_next;
    logic [6:0]                len_reg, len_next;
    logic                      last_reg, last_next;

    logic                      out_free;
    logic                      accept;
    logic                      emit;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !(state_reg == S_IDLE && out_free);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        key_next        = key_reg;
        pend_valid_next = pend_valid_reg;
        pend_pos_next   = pend_pos_reg;
        pend_idx_next   = pend_idx_reg;
        cmd             = '{kind: sle_pkg::CMD_HOLD, pos: '0, count: count_reg};
        emit            = 1'b0;
        status_next     = sle_pkg::STAT_OK;
        mpos_next       = '0;
        midx_next       = '0;
        last_next       = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        sle_pkg::OP_APPEND:
                        begin
                            emit = 1'b1;
                            if (count_reg >= CAP_CNT)
                                status_next = sle_pkg::STAT_FULL;
                            else
                            begin
                                cmd.kind   = sle_pkg::CMD_APPEND;
                                cmd.pos    = count_reg[sle_pkg::IDX_W-1:0];
                                count_next = count_reg + ONE;
                            end
                        end
                        sle_pkg::OP_INSERT:
                        begin
                            emit = 1'b1;
                            if (count_reg >= CAP_CNT)
                                status_next = sle_pkg::STAT_FULL;
                            else if (position == '0 ||
                                     {1'b0, position} > ({1'b0, count_reg} + 8'd1))
                                status_next = sle_pkg::STAT_BADPOS;
                            else
                            begin
                                cmd.kind   = sle_pkg::CMD_INSERT;
                                cmd.pos    = sle_pkg::IDX_W'(position - 7'd1);
                                count_next = count_reg + ONE;
                            end
                        end
                        sle_pkg::OP_DELETE:
                        begin
                            emit = 1'b1;
                            if (position == '0 || position > count_reg)
                                status_next = sle_pkg::STAT_BADPOS;
                            else
                            begin
                                cmd.kind   = sle_pkg::CMD_DELETE;
                                cmd.pos    = sle_pkg::IDX_W'(position - 7'd1);
                                count_next = count_reg - ONE;
                            end
                        end
                        sle_pkg::OP_FIND:
                        begin
                            key_next        = value;
                            scan_next       = '0;
                            pend_valid_next = 1'b0;
                            state_next      = (count_reg == '0) ? S_FLUSH : S_SCAN;
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // one entry reaches the head per step; rotate the list through it
                if (out_free)
                begin
                    cmd.kind  = sle_pkg::CMD_ROTATE;
                    scan_next = scan_reg + ONE;
                    if (head_data == key_reg)
                    begin
                        if (pend_valid_reg)
                        begin
                            emit      = 1'b1;
                            mpos_next = pend_pos_reg;
                            midx_next = pend_idx_reg;
                            last_next = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_pos_next   = scan_reg + ONE;
                        pend_idx_next   = pend_valid_reg ? pend_idx_reg + 7'd1 : 7'd1;
                    end
                    if (scan_reg == count_reg - ONE)
                        state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (pend_valid_reg)
                    begin
                        mpos_next = pend_pos_reg;
                        midx_next = pend_idx_reg;
                    end
                    else
                        status_next = sle_pkg::STAT_NOTFOUND;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        len_next       = count_next;
        out_valid_next = emit ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        key_reg      <= key_next;
        pend_pos_reg <= pend_pos_next;
        pend_idx_reg <= pend_idx_next;
        if (emit)
        begin
            status_reg <= status_next;
            mpos_reg   <= mpos_next;
            midx_reg   <= midx_next;
            len_reg    <= len_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign match_position = mpos_reg;
    assign match_index    = midx_reg;
    assign length         = len_reg;
    assign last           = last_reg;

    `SLE_ASSERT_IMPLY(a_ready_only_idle, clk, rst_n, !in_stall, state_reg == S_IDLE)
    `SLE_ASSERT_IMPLY(a_count_in_range, clk, rst_n, 1'b1, count_reg <= CAP_CNT)
    `SLE_ASSERT_IMPLY(a_scan_bounds, clk, rst_n, state_reg == S_SCAN,
        (count_reg != '0) && (scan_reg < count_reg))
    `SLE_ASSERT_NEXT(a_append_grows, clk, rst_n,
        accept && (op == sle_pkg::OP_APPEND) && (count_reg < CAP_CNT),
        count_reg == $past(count_reg) + ONE)
    `SLE_ASSERT_NEXT(a_emit_shows, clk, rst_n, emit, out_valid_reg)

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for sequential_list_engine_unit: a list predictor in a
// scoreboard class, tasks that drive the input and a process that stalls the output at random.
// Depends on sle_pkg and the RTL of the list engine.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sle_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 87;
    localparam int DRAIN_CYCLES  = 70;   // room for a find to run to its end

    // One result as the engine reports it.
    typedef struct {
        logic [1:0] status;
        logic [6:0] match_position;
        logic [6:0] match_index;
        logic [6:0] length;
        logic       last;
    } list_result_t;

    // Scoreboard: holds its own copy of the list and the results still owed.
    class list_scoreboard;
        elem_t        store [CAPACITY];
        int           fill;
        list_result_t owed [$];
        int           mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        function void owe(logic [1:0] st, int mpos, int midx, logic fin);
            list_result_t r;
            r.status         = st;
            r.match_position = mpos[6:0];
            r.match_index    = midx[6:0];
            r.length         = fill[6:0];
            r.last           = fin;
            owed.push_back(r);
        endfunction

        // Apply one accepted transfer to the list and queue what it must produce.
        function void note_input(logic [1:0] opc, logic [6:0] pos7, elem_t val);
            int pos;
            int hits;
            pos = pos7;
            case (opc)
                OP_APPEND:
                    if (fill >= CAPACITY) owe(STAT_FULL, 0, 0, 1'b1);
                    else
                    begin
                        store[fill] = val;
                        fill++;
                        owe(STAT_OK, 0, 0, 1'b1);
                    end
                OP_INSERT:
                    if (fill >= CAPACITY) owe(STAT_FULL, 0, 0, 1'b1);
                    else if (pos < 1 || pos > fill + 1) owe(STAT_BADPOS, 0, 0, 1'b1);
                    else
                    begin
                        for (int i = fill; i >= pos; i--)
                            store[i] = store[i-1];
                        store[pos-1] = val;
                        fill++;
                        owe(STAT_OK, 0, 0, 1'b1);
                    end
                OP_DELETE:
                    if (pos < 1 || pos > fill) owe(STAT_BADPOS, 0, 0, 1'b1);
                    else
                    begin
                        for (int i = pos; i < fill; i++)
                            store[i-1] = store[i];
                        fill--;
                        owe(STAT_OK, 0, 0, 1'b1);
                    end
                default:
                begin
                    hits = 0;
                    for (int i = 0; i < fill; i++)
                        if (store[i] == val)
                        begin
                            hits++;
                            owe(STAT_OK, i + 1, hits, 1'b0);
                        end
                    if (hits == 0) owe(STAT_NOTFOUND, 0, 0, 1'b1);
                    else owed[owed.size()-1].last = 1'b1;
                end
            endcase
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            if (mismatches < 10)
                $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        endfunction

        function void check_result(list_result_t got);
            list_result_t want;
            if (owed.size() == 0)
            begin
                if (mismatches < 10)
                    $display("[%0t] result transfer with nothing outstanding", $time);
                mismatches++;
                return;
            end
            want = owed.pop_front();
            if (want.status !== got.status) report("status", want.status, got.status);
            if (want.match_position !== got.match_position)
                report("match_position", want.match_position, got.match_position);
            if (want.match_index !== got.match_index)
                report("match_index", want.match_index, got.match_index);
            if (want.length !== got.length) report("length", want.length, got.length);
            if (want.last !== got.last) report("last", want.last, got.last);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] op;
    logic [6:0] position;
    elem_t      value;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] status;
    logic [6:0] match_position;
    logic [6:0] match_index;
    logic [6:0] length;
    logic       last;

    list_scoreboard sb;
    int             idle_mode;
    int             cycles;

    // Small pool of values so lists carry duplicates and finds hit often;
    // the extremes of the signed range sit in it.
    elem_t value_pool [8] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sh1,
                              32'sh5555_5555, -32'sh5555_5556, 32'sd17, -32'sd17};

    sequential_list_engine_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .position       (position),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .match_position (match_position),
        .match_index    (match_index),
        .length         (length),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Gap ahead of the next input transfer. The idle mode changes now and then,
    // so some stretches run back to back and others carry short or long gaps.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        case (idle_mode)
            0: return 0;
            1: return (r < 50) ? 0 : $urandom_range(1, 2);
            default: return (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3)
                                                    : $urandom_range(5, 25);
        endcase
    endfunction

    // Present one transfer and hold it until the engine takes it. Called
    // right after a rising edge, so every assignment lands on that edge.
    task automatic send_item(logic [1:0] opc, logic [6:0] pos, elem_t val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= opc;
        position <= pos;
        value    <= val;
        // The transfer happens at the first edge where stall was low.
        do @(posedge clk); while (in_stall);
        sb.note_input(opc, pos, val);
    endtask

    function automatic elem_t pick_value();
        if ($urandom_range(0, 99) < 60) return value_pool[$urandom_range(0, 7)];
        return elem_t'($urandom);
    endfunction

    // Draw one well-formed or noisy transfer. Until the list has been full
    // once, the mix leans on growth; after that it hovers near capacity.
    task automatic send_random(bit grow);
        int    r;
        int    rp;
        logic [6:0] pos;
        elem_t val;
        r   = $urandom_range(0, 99);
        rp  = $urandom_range(0, 99);
        val = pick_value();
        pos = 7'($urandom_range(0, 127));
        if (r < (grow ? 55 : 20))
            send_item(OP_APPEND, pos, val);
        else if (r < (grow ? 85 : 40))
        begin
            if (rp < 85) pos = 7'($urandom_range(1, sb.fill + 1));
            send_item(OP_INSERT, pos, val);
        end
        else if (r < (grow ? 90 : 70))
        begin
            if (rp < 85 && sb.fill > 0) pos = 7'($urandom_range(1, sb.fill));
            send_item(OP_DELETE, pos, val);
        end
        else
        begin
            // Search mostly for values that are present.
            if (rp < 50 && sb.fill > 0) val = sb.store[$urandom_range(0, sb.fill - 1)];
            else if (rp >= 80) val = elem_t'($urandom);
            send_item(OP_FIND, pos, val);
        end
    endtask

    // Result side: random stall bursts, mostly short, a few long, and some
    // long runs with no stall at all. Check each transfer as it happens.
    initial
    begin : result_side
        int         stall_left;
        int         run_left;
        int         r;
        logic       hold;
        list_result_t got;
        stall_left = 0;
        run_left   = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.status         = status;
                got.match_position = match_position;
                got.match_index    = match_index;
                got.length         = length;
                got.last           = last;
                sb.check_result(got);
            end
            if (stall_left == 0 && run_left == 0)
            begin
                r = $urandom_range(0, 9);
                if (r < 5) run_left = $urandom_range(1, 8);
                else if (r < 8) stall_left = $urandom_range(1, 3);
                else if (r == 8) stall_left = $urandom_range(4, 20);
                else run_left = $urandom_range(20, 60);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                hold = 1'b1;
            end
            else
            begin
                run_left--;
                hold = 1'b0;
            end
            out_stall <= hold;
        end
    end

    // Watchdog on the whole run.
    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("sequential_list_engine_unit regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        bit reached_full;
        int n;
        sb           = new();
        idle_mode    = 0;
        reached_full = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = OP_APPEND;
        position     = '0;
        value        = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty-list corner cases, the value extremes, both
        // list ends for insert and delete, and finds with several hits.
        idle_mode = 1;
        send_item(OP_FIND,   7'd0,   32'sh0);            // find on empty list
        send_item(OP_DELETE, 7'd1,   32'sh0);            // delete on empty list
        send_item(OP_INSERT, 7'd0,   32'sh1);            // position zero
        send_item(OP_INSERT, 7'd2,   32'sh1);            // past length + 1
        send_item(OP_INSERT, 7'd1,   32'sh7FFF_FFFF);    // insert into empty
        send_item(OP_APPEND, 7'd127, 32'sh8000_0000);
        send_item(OP_APPEND, 7'd0,   32'sh0);
        send_item(OP_APPEND, 7'd0,   -32'sh1);
        send_item(OP_INSERT, 7'd5,   -32'sh1);           // at length + 1
        send_item(OP_INSERT, 7'd1,   32'sh0);            // at the head
        send_item(OP_INSERT, 7'd3,   32'sh8000_0000);    // in the middle
        send_item(OP_INSERT, 7'd127, 32'sh2);            // far out of range
        send_item(OP_FIND,   7'd127, -32'sh1);           // several hits
        send_item(OP_FIND,   7'd0,   32'sh8000_0000);
        send_item(OP_FIND,   7'd0,   32'sh1234_5678);    // no hit
        send_item(OP_DELETE, 7'd0,   32'sh0);            // position zero
        send_item(OP_DELETE, 7'd127, 32'sh0);            // far out of range
        send_item(OP_DELETE, 7'd1,   32'sh0);            // head
        send_item(OP_DELETE, 7'(sb.fill), 32'sh0);       // tail
        send_item(OP_DELETE, 7'd3,   32'sh0);            // middle
        send_item(OP_FIND,   7'd0,   32'sh0);
        send_item(OP_APPEND, 7'd85,  32'sh5555_5555);
        send_item(OP_APPEND, 7'd42,  -32'sh5555_5556);

        // Random part: keep going past the item count until the list has
        // been full at least once.
        n = 0;
        while (n < RANDOM_ITEMS || !reached_full)
        begin
            if (n % 16 == 0) idle_mode = $urandom_range(0, 3);
            send_random(!reached_full);
            if (sb.fill == CAPACITY) reached_full = 1'b1;
            n++;
        end
        in_valid <= 1'b0;

        // Drain: wait for every owed result, then let the engine settle.
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.owed.size() == 0)
            $display("sequential_list_engine_unit regression: pass");
        else
            $display("sequential_list_engine_unit regression: fail");
        $finish;
    end

endmodule
